// File: rtl/chaikin_pkg.sv
// Shared constants and types for the Chaikin oscillator block.
package chaikin_pkg;

   localparam int unsigned PERIOD_W    = 11;
   localparam int unsigned PERIOD_MAX  = 1024;
   localparam int unsigned FAST_RESET  = 3;
   localparam int unsigned SLOW_RESET  = 10;
   localparam int unsigned MULT_FRAC   = 30;
   localparam int unsigned LINE_FRAC   = 16;
   localparam int unsigned PROD_SHIFT  = MULT_FRAC - LINE_FRAC;
   localparam int unsigned DVD_W       = 65;
   localparam int unsigned DIV_STEPS   = DVD_W;
   localparam int unsigned CNT_W       = $clog2(DIV_STEPS + 1);
   localparam int unsigned ADDR_W      = 3;

   // Register index, taken from paddr[2]
   localparam logic REG_FAST = 1'b0;
   localparam logic REG_SLOW = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_MDIV   = 11'b000_0000_0010,
      ST_MUL    = 11'b000_0000_0100,
      ST_ACC    = 11'b000_0000_1000,
      ST_FSTART = 11'b000_0001_0000,
      ST_FDIV   = 11'b000_0010_0000,
      ST_FUPD   = 11'b000_0100_0000,
      ST_SDIV   = 11'b000_1000_0000,
      ST_SUPD   = 11'b001_0000_0000,
      ST_OSC    = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

endpackage

// File: rtl/chaikin_oscillator_top.sv
// Chaikin oscillator: sequencer around one shared restoring divider.
//
// One price bar per transaction. Each bar goes through the single bit-per-cycle
// restoring divider in up to three 65-step passes (money-flow multiplier, fast
// average step, slow average step), with states for the multiply, the
// saturating line update and the final difference. A bar with high <= low or
// with |2*close - low - high| >= 2*(high - low) skips the first divider pass;
// the first bar after reset seeds both averages and skips the two average
// passes. The block holds one bar at a time: req_ready is high only while
// the sequencer is idle, and the result sits in an output register until
// taken. fast_period / slow_period are at byte addresses 0 and 4 and must be
// written only while the block is idle.
module chaikin_oscillator_top (
   input  logic                             clock,
   input  logic                             reset,
   // bar input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [31:0]                      req_bar_high,
   input  logic [31:0]                      req_bar_low,
   input  logic [31:0]                      req_bar_close,
   input  logic [31:0]                      req_bar_volume,
   // result
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [63:0]               rsp_oscillator,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [chaikin_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int unsigned PW = chaikin_pkg::PERIOD_W;
   localparam int unsigned DW = chaikin_pkg::DVD_W;
   localparam int unsigned CW = chaikin_pkg::CNT_W;

   chaikin_pkg::state_type state_ff, state_in;

   logic [PW-1:0]  fast_per_ff, slow_per_ff;
   logic [31:0]    vol_ff;
   logic           mneg_ff, mneg_in;
   logic [31:0]    mmag_ff, mmag_in;
   logic [63:0]    prod_ff;
   logic [DW-1:0]  dvd_ff, dvd_in;
   logic [31:0]    rem_ff, rem_in;
   logic [31:0]    dvsr_ff, dvsr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           uneg_ff, uneg_in;
   logic [63:0]    accum_ff, accum_in;
   logic [63:0]    fast_ff, fast_in;
   logic [63:0]    slow_ff, slow_in;
   logic           seeded_ff, seeded_in;
   logic [63:0]    osc_ff, osc_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // ---------------- register port ----------------
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_comb begin
      if (paddr[2] == chaikin_pkg::REG_FAST) begin
         prdata = {{(32-PW){1'b0}}, fast_per_ff};
      end else begin
         prdata = {{(32-PW){1'b0}}, slow_per_ff};
      end
   end

   // Clamp periods to 1..1024, then order them so the fast one is shorter.
   logic [PW-1:0] pf_c, ps_c, per_lo, per_hi;
   always_comb begin
      pf_c = fast_per_ff;
      ps_c = slow_per_ff;
      if (fast_per_ff == '0) pf_c = PW'(1);
      else if (fast_per_ff > PW'(chaikin_pkg::PERIOD_MAX)) pf_c = PW'(chaikin_pkg::PERIOD_MAX);
      if (slow_per_ff == '0) ps_c = PW'(1);
      else if (slow_per_ff > PW'(chaikin_pkg::PERIOD_MAX)) ps_c = PW'(chaikin_pkg::PERIOD_MAX);
      per_lo = (pf_c > ps_c) ? ps_c : pf_c;
      per_hi = (pf_c > ps_c) ? pf_c : ps_c;
   end

   // ---------------- bar decode ----------------
   // num = 2*close - low - high, span = high - low
   logic signed [34:0] num;
   logic        [33:0] nmag;
   logic        [32:0] span;
   logic               flat, clipped;
   always_comb begin
      num  = $signed({2'b00, req_bar_close, 1'b0})
           - $signed({3'b000, req_bar_low}) - $signed({3'b000, req_bar_high});
      nmag = num[34] ? 34'(-num) : num[33:0];
      span = {1'b0, req_bar_high} - {1'b0, req_bar_low};
      flat = (req_bar_high <= req_bar_low);
      clipped = (nmag >= {span[31:0], 1'b0});
   end

   // ---------------- shared divider step ----------------
   logic [32:0] shifted;
   logic [32:0] trial;
   logic        ge;
   always_comb begin
      shifted = {rem_ff, dvd_ff[DW-1]};
      trial   = shifted - {1'b0, dvsr_ff};
      ge      = (shifted >= {1'b0, dvsr_ff});
   end

   // ---------------- average helpers ----------------
   // d = accum - avg as 65-bit signed, magnitude always fits 64 bits
   logic [64:0] fdiff, sdiff;
   logic [63:0] fdmag, sdmag;
   always_comb begin
      fdiff = {accum_ff[63], accum_ff} - {fast_ff[63], fast_ff};
      sdiff = {accum_ff[63], accum_ff} - {slow_ff[63], slow_ff};
      fdmag = fdiff[64] ? 64'(-fdiff) : fdiff[63:0];
      sdmag = sdiff[64] ? 64'(-sdiff) : sdiff[63:0];
   end

   // saturating line update and oscillator difference
   logic [63:0] delta;
   logic [64:0] acc_sum, osc_diff;
   always_comb begin
      delta    = mneg_ff ? 64'(-prod_ff) : prod_ff;
      acc_sum  = {accum_ff[63], accum_ff} + {delta[63], delta};
      osc_diff = {fast_ff[63], fast_ff} - {slow_ff[63], slow_ff};
   end

   // ---------------- sequencer ----------------
   assign req_ready = (state_ff == chaikin_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_oscillator = $signed(osc_ff);

   always_comb begin
      state_in     = state_ff;
      mneg_in      = mneg_ff;
      mmag_in      = mmag_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      cnt_in       = cnt_ff;
      uneg_in      = uneg_ff;
      accum_in     = accum_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      seeded_in    = seeded_ff;
      osc_in       = osc_ff;
      rsp_valid_in = rsp_valid_ff;

      // divider runs in any of its states
      if (state_ff == chaikin_pkg::ST_MDIV || state_ff == chaikin_pkg::ST_FDIV ||
          state_ff == chaikin_pkg::ST_SDIV) begin
         rem_in = ge ? trial[31:0] : shifted[31:0];
         dvd_in = {dvd_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
      end

      unique case (state_ff)
         chaikin_pkg::ST_IDLE: begin
            if (req_valid) begin
               mneg_in = num[34];
               rem_in  = '0;
               dvsr_in = span[31:0];
               cnt_in  = CW'(chaikin_pkg::DIV_STEPS);
               dvd_in  = DW'({nmag, 30'd0});
               if (flat) begin
                  mmag_in  = '0;
                  state_in = chaikin_pkg::ST_MUL;
               end else if (clipped) begin
                  mmag_in  = num[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  state_in = chaikin_pkg::ST_MUL;
               end else begin
                  state_in = chaikin_pkg::ST_MDIV;
               end
            end
         end
         chaikin_pkg::ST_MDIV: begin
            if (cnt_ff == CW'(1)) begin
               mmag_in  = {1'b0, dvd_in[30:0]};
               state_in = chaikin_pkg::ST_MUL;
            end
         end
         chaikin_pkg::ST_MUL: begin
            state_in = chaikin_pkg::ST_ACC;
         end
         chaikin_pkg::ST_ACC: begin
            if (acc_sum[64] != acc_sum[63]) begin
               accum_in = acc_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
               accum_in = acc_sum[63:0];
            end
            if (!seeded_ff) begin
               fast_in      = accum_in;
               slow_in      = accum_in;
               seeded_in    = 1'b1;
               osc_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = chaikin_pkg::ST_OUT;
            end else begin
               state_in = chaikin_pkg::ST_FSTART;
            end
         end
         chaikin_pkg::ST_FSTART: begin
            // step = floor(2*|d| / (period+1))
            uneg_in  = fdiff[64];
            dvd_in   = {fdmag, 1'b0};
            rem_in   = '0;
            dvsr_in  = 32'({1'b0, per_lo} + 12'd1);
            cnt_in   = CW'(chaikin_pkg::DIV_STEPS);
            state_in = chaikin_pkg::ST_FDIV;
         end
         chaikin_pkg::ST_FDIV: begin
            if (cnt_ff == CW'(1)) state_in = chaikin_pkg::ST_FUPD;
         end
         chaikin_pkg::ST_FUPD: begin
            fast_in  = uneg_ff ? (fast_ff - dvd_ff[63:0]) : (fast_ff + dvd_ff[63:0]);
            uneg_in  = sdiff[64];
            dvd_in   = {sdmag, 1'b0};
            rem_in   = '0;
            dvsr_in  = 32'({1'b0, per_hi} + 12'd1);
            cnt_in   = CW'(chaikin_pkg::DIV_STEPS);
            state_in = chaikin_pkg::ST_SDIV;
         end
         chaikin_pkg::ST_SDIV: begin
            if (cnt_ff == CW'(1)) state_in = chaikin_pkg::ST_SUPD;
         end
         chaikin_pkg::ST_SUPD: begin
            slow_in  = uneg_ff ? (slow_ff - dvd_ff[63:0]) : (slow_ff + dvd_ff[63:0]);
            state_in = chaikin_pkg::ST_OSC;
         end
         chaikin_pkg::ST_OSC: begin
            if (osc_diff[64] != osc_diff[63]) begin
               osc_in = osc_diff[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
               osc_in = osc_diff[63:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = chaikin_pkg::ST_OUT;
         end
         chaikin_pkg::ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = chaikin_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chaikin_pkg::ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chaikin_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seeded_ff    <= 1'b0;
         accum_ff     <= '0;
         fast_ff      <= '0;
         slow_ff      <= '0;
         fast_per_ff  <= PW'(chaikin_pkg::FAST_RESET);
         slow_per_ff  <= PW'(chaikin_pkg::SLOW_RESET);
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seeded_ff    <= seeded_in;
         accum_ff     <= accum_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         cnt_ff       <= cnt_in;
         if (cfg_wr) begin
            if (paddr[2] == chaikin_pkg::REG_FAST) fast_per_ff <= pwdata[PW-1:0];
            else                                   slow_per_ff <= pwdata[PW-1:0];
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      mneg_ff <= mneg_in;
      mmag_ff <= mmag_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      uneg_ff <= uneg_in;
      osc_ff  <= osc_in;
      if (req_valid && req_ready) vol_ff <= req_bar_volume;
      if (state_ff == chaikin_pkg::ST_MUL) begin
         prod_ff <= (64'(mmag_ff) * 64'(vol_ff)) >> chaikin_pkg::PROD_SHIFT;
      end
   end

   // ---------------- assertions ----------------
   a_one_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result is pending");

   a_seed_first: assert property (@(posedge clock) disable iff (reset)
      !seeded_ff |-> !rsp_valid)
      else $error("result presented before the averages were seeded");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer did not leave idle after accepting a bar");

endmodule
